[sv/dpsa_pkg.sv]
// ----------------------------------------------------------------------------
// dpsa_pkg
// Shared constants and field widths of the deduplicating palette slot
// allocator: table depth, base arithmetic and stream packing.
// ----------------------------------------------------------------------------
package dpsa_pkg;

    // Table and base arithmetic
    localparam int PALETTE_SLOTS    = 512;
    localparam int BONES_PER_POSE   = 256;
    localparam int FRAMES_IN_FLIGHT = 3;

    // Field widths
    localparam int KEY_W     = 64;
    localparam int SERIAL_W  = 64;
    localparam int COUNTER_W = 32;
    localparam int BASE_W    = 19;

    // Slot index and fill count (the count must hold PALETTE_SLOTS itself)
    localparam int ADDR_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
    localparam int FILL_W = $clog2(PALETTE_SLOTS + 1);

    // Remainder of the frame counter by FRAMES_IN_FLIGHT
    localparam int MOD_W  = (FRAMES_IN_FLIGHT > 1) ? $clog2(FRAMES_IN_FLIGHT) : 1;

    // Reciprocal for the remainder: quotient = (counter * MOD_RECIP) >> MOD_SHIFT,
    // exact for every counter value with MOD_RECIP = ceil(2^MOD_SHIFT / frames)
    localparam int MOD_SHIFT = COUNTER_W + $clog2(FRAMES_IN_FLIGHT);
    localparam int RECIP_W   = COUNTER_W + 1;
    localparam int PROD_W    = COUNTER_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'(((64'd1 << MOD_SHIFT)
        + 64'(FRAMES_IN_FLIGHT) - 64'd1) / 64'(FRAMES_IN_FLIGHT));

    // Base offsets, wrapped to the base width
    localparam logic [BASE_W-1:0] FRAME_STRIDE = BASE_W'(PALETTE_SLOTS * BONES_PER_POSE);
    localparam logic [BASE_W-1:0] SLOT_STRIDE  = BASE_W'(BONES_PER_POSE);

    // One table entry: key in the upper bits, base in the lower bits
    localparam int ENTRY_W = KEY_W + BASE_W;

    // Stream packing
    localparam int IN_DATA_W  = 224;  // pose id, requester id, serial, counter
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;   // palette base padded to whole bytes
    localparam int OUT_USER_W = 3;

    // Input tuser bit positions
    localparam int IU_SKIN  = 0;
    localparam int IU_READY = 1;
    localparam int IU_POSE  = 2;

    // Output tuser bit positions
    localparam int OU_VALID = 0;
    localparam int OU_NEW   = 1;
    localparam int OU_OVF   = 2;

endpackage

[sv/dpsa_slot_ram.sv]
// ----------------------------------------------------------------------------
// dpsa_slot_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpsa_slot_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 83
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/dpsa_mod_unit.sv]
// ----------------------------------------------------------------------------
// dpsa_mod_unit
// Remainder of the frame counter by the number of frames in flight, by
// reciprocal multiplication: the product is registered at start, and the
// remainder is formed from it and registered on the next clock.
// ----------------------------------------------------------------------------
module dpsa_mod_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [dpsa_pkg::COUNTER_W-1:0]     i_value,
    output logic                               o_done,
    output logic [dpsa_pkg::MOD_W-1:0]         o_result
);

    logic                             r_busy;
    logic                             r_done;
    logic [dpsa_pkg::COUNTER_W-1:0]   r_val;
    logic [dpsa_pkg::PROD_W-1:0]      r_prod;
    logic [dpsa_pkg::MOD_W-1:0]       r_acc;
    logic [dpsa_pkg::COUNTER_W-1:0]   quot;
    logic [dpsa_pkg::COUNTER_W-1:0]   rem;

    // Quotient from the product, remainder by one multiply-back and subtract
    assign quot = dpsa_pkg::COUNTER_W'(r_prod >> dpsa_pkg::MOD_SHIFT);
    assign rem  = r_val - quot * dpsa_pkg::COUNTER_W'(dpsa_pkg::FRAMES_IN_FLIGHT);

    // Step control: start, then done in the cycle after the product is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_prod <= dpsa_pkg::PROD_W'(i_value) * dpsa_pkg::PROD_W'(dpsa_pkg::MOD_RECIP);
        end
        if (r_busy) begin
            r_acc <= dpsa_pkg::MOD_W'(rem);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

[sv/dedup_palette_slot_allocator.sv]
// ----------------------------------------------------------------------------
// dedup_palette_slot_allocator
// Palette slot allocator that hands out one matrix base per key and frame,
// returning the same base to repeated keys.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on s_axis, one result per request leaves on m_axis, in
//   order. s_axis_tready is high only while the sequencer is idle; one
//   request is taken per transfer and the block stays busy until its result
//   has moved into the output register.
//   Not skinned or buffer not ready: the result goes through the done state
//   to the output register and the table is left alone.
//   Otherwise: the frame-counter remainder (reciprocal multiply), a scan of
//   the filled slots at one RAM read per cycle, then the load of the result.
//   A hit ends the scan at the matching slot; a new slot or a full table is
//   decided once every filled slot has been read. The next request can be
//   taken in the cycle after the result is loaded.
//   A stalled receiver holds the result in the output register; a following
//   result waits in the sequencer, with s_axis_tready low, until it frees.
//   Reset empties the table (fill count zero), clears the overflow mark and
//   sets the last frame serial to all ones; table RAM is not cleared, as
//   only filled slots are ever searched.
// ----------------------------------------------------------------------------
module dedup_palette_slot_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] pose_identity, [127:64] requester_id, [191:128] frame_serial,
    // [223:192] frame_counter
    input  logic [dpsa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] has_skinning, [1] palette_ready, [2] pose_present
    input  logic [dpsa_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [18:0] palette_base, [23:19] zero
    output logic [dpsa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] base_valid, [1] newly_allocated, [2] overflow_report
    output logic [dpsa_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                              r_state;
    logic [dpsa_pkg::FILL_W-1:0]         r_fill;
    logic [dpsa_pkg::SERIAL_W-1:0]       r_last_serial;
    logic                                r_ovf_reported;
    logic [dpsa_pkg::KEY_W-1:0]          r_key;
    logic [dpsa_pkg::FILL_W-1:0]         r_rd_idx;
    logic                                r_pend;
    logic                                r_res_valid;
    logic [dpsa_pkg::BASE_W-1:0]         r_res_base;
    logic                                r_res_new;
    logic                                r_res_ovf;
    logic                                r_out_valid;
    logic [dpsa_pkg::BASE_W-1:0]         r_out_base;
    logic                                r_out_new;
    logic                                r_out_ovf;
    logic                                r_out_bvalid;

    logic                                mod_start;
    logic                                mod_done;
    logic [dpsa_pkg::MOD_W-1:0]          mod_result;
    logic                                rd_en;
    logic                                hit;
    logic                                wr_en;
    logic [dpsa_pkg::ENTRY_W-1:0]        rd_data;
    logic [dpsa_pkg::BASE_W-1:0]         new_base;
    logic                                in_xfer;
    logic                                out_xfer;
    logic                                out_load;
    logic [dpsa_pkg::KEY_W-1:0]          in_key;
    logic                                in_active;

    // Input field decode
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_xfer  = m_axis_tvalid && m_axis_tready;
    assign in_active = s_axis_tuser[dpsa_pkg::IU_SKIN] && s_axis_tuser[dpsa_pkg::IU_READY];
    assign in_key    = s_axis_tuser[dpsa_pkg::IU_POSE] ? s_axis_tdata[63:0]
                                                       : s_axis_tdata[127:64];

    // Result moves into the output register when it is free or draining
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Scan control: issue one read per cycle, compare the entry in the next cycle
    assign rd_en = (r_state == ST_SCAN) && (r_rd_idx < r_fill);
    assign hit   = (r_state == ST_SCAN) && r_pend
                   && (rd_data[dpsa_pkg::ENTRY_W-1:dpsa_pkg::BASE_W] == r_key);
    assign wr_en = (r_state == ST_SCAN) && !r_pend && !rd_en && !hit
                   && (r_fill < dpsa_pkg::FILL_W'(dpsa_pkg::PALETTE_SLOTS));

    assign mod_start = (r_state == ST_IDLE) && in_xfer && in_active;

    // Base of the next free slot
    assign new_base = dpsa_pkg::BASE_W'(mod_result) * dpsa_pkg::FRAME_STRIDE
                    + dpsa_pkg::BASE_W'(r_fill) * dpsa_pkg::SLOT_STRIDE;

    dpsa_mod_unit u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_value  (s_axis_tdata[223:192]),
        .o_done   (mod_done),
        .o_result (mod_result)
    );

    dpsa_slot_ram #(
        .DEPTH (dpsa_pkg::PALETTE_SLOTS),
        .WIDTH (dpsa_pkg::ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[dpsa_pkg::ADDR_W-1:0]),
        .i_wr_data ({r_key, new_base}),
        .i_rd_addr (r_rd_idx[dpsa_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Sequencer, table state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_fill         <= '0;
            r_last_serial  <= '1;
            r_ovf_reported <= 1'b0;
            r_pend         <= 1'b0;
            r_rd_idx       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_key       <= in_key;
                        r_res_valid <= 1'b0;
                        r_res_base  <= '0;
                        r_res_new   <= 1'b0;
                        r_res_ovf   <= 1'b0;
                        if (in_active) begin
                            if (s_axis_tdata[191:128] != r_last_serial) begin
                                r_last_serial  <= s_axis_tdata[191:128];
                                r_fill         <= '0;
                                r_ovf_reported <= 1'b0;
                            end
                            r_state <= ST_MOD;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_MOD: begin
                    if (mod_done) begin
                        r_rd_idx <= '0;
                        r_pend   <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (hit) begin
                        r_res_valid <= 1'b1;
                        r_res_base  <= rd_data[dpsa_pkg::BASE_W-1:0];
                        r_state     <= ST_DONE;
                    end else if (!r_pend && !rd_en) begin
                        // Miss: take the next slot, or flag a full table the first time in a frame
                        if (wr_en) begin
                            r_fill      <= r_fill + 1'b1;
                            r_res_valid <= 1'b1;
                            r_res_base  <= new_base;
                            r_res_new   <= 1'b1;
                        end else begin
                            r_res_ovf      <= !r_ovf_reported;
                            r_ovf_reported <= 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output payload follows the result when it moves into the register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_bvalid <= r_res_valid;
            r_out_base   <= r_res_base;
            r_out_new    <= r_res_new;
            r_out_ovf    <= r_res_ovf;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(dpsa_pkg::OUT_DATA_W - dpsa_pkg::BASE_W)'(0), r_out_base};
    assign m_axis_tuser  = {r_out_ovf, r_out_new, r_out_bvalid};

endmodule

[tb/sv/tb_dedup_palette_slot_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_palette_slot_allocator
// Self-checking bench for the palette slot allocator. Requests are sent over
// the s_axis stream with random gaps. Results on m_axis are taken under
// random back-pressure. Each result is compared with a local model of the key
// table, which is run on every accepted request. The directed tests cover
// refused requests, key sharing between pose and requester ids, and frame
// restarts. One test fills the table to overflow. A random run follows,
// made mostly of well-formed frames with repeated keys.
// ----------------------------------------------------------------------------
module tb_dedup_palette_slot_allocator;

    // One request and one result, in field form
    typedef struct {
        bit                                skin;
        bit                                ready;
        bit                                pose_present;
        bit [dpsa_pkg::KEY_W-1:0]          pose_id;
        bit [dpsa_pkg::KEY_W-1:0]          req_id;
        bit [dpsa_pkg::SERIAL_W-1:0]       serial;
        bit [dpsa_pkg::COUNTER_W-1:0]      counter;
    } t_palette_req;

    typedef struct {
        bit                                base_valid;
        bit [dpsa_pkg::BASE_W-1:0]         base;
        bit                                newly;
        bit                                overflow;
    } t_palette_res;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    // [63:0] pose_identity, [127:64] requester_id, [191:128] frame_serial,
    // [223:192] frame_counter
    logic [dpsa_pkg::IN_DATA_W-1:0]        s_axis_tdata;
    // [0] has_skinning, [1] palette_ready, [2] pose_present
    logic [dpsa_pkg::IN_USER_W-1:0]        s_axis_tuser;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    // [18:0] palette_base, [23:19] zero
    logic [dpsa_pkg::OUT_DATA_W-1:0]       m_axis_tdata;
    // [0] base_valid, [1] newly_allocated, [2] overflow_report
    logic [dpsa_pkg::OUT_USER_W-1:0]       m_axis_tuser;

    // Local copy of the allocator state
    bit [dpsa_pkg::KEY_W-1:0]    stored_keys [dpsa_pkg::PALETTE_SLOTS];
    bit [dpsa_pkg::BASE_W-1:0]   stored_bases[dpsa_pkg::PALETTE_SLOTS];
    int                          slot_fill     = 0;
    bit [dpsa_pkg::SERIAL_W-1:0] last_serial   = '1;
    bit                          overflow_seen = 1'b0;

    t_palette_res expected_bases[$];
    int           mismatch_count  = 0;
    int           results_checked = 0;
    bit           calm_stretch    = 1'b0;
    int           stall_left      = 0;

    dedup_palette_slot_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Looks up or allocates the base for one request and updates the table
    function automatic t_palette_res allocate_palette_base(input t_palette_req req);
        t_palette_res                res;
        bit [dpsa_pkg::KEY_W-1:0]    key;
        longint unsigned             full_base;
        int                          slot;
        res = '{default: '0};
        if (!req.skin || !req.ready) begin
            return res;
        end
        if (req.serial != last_serial) begin
            last_serial   = req.serial;
            slot_fill     = 0;
            overflow_seen = 1'b0;
        end
        key = req.pose_present ? req.pose_id : req.req_id;
        for (slot = 0; slot < slot_fill; slot++) begin
            if (stored_keys[slot] == key) begin
                res.base_valid = 1'b1;
                res.base       = stored_bases[slot];
                return res;
            end
        end
        if (slot_fill >= dpsa_pkg::PALETTE_SLOTS) begin
            if (!overflow_seen) begin
                overflow_seen = 1'b1;
                res.overflow  = 1'b1;
            end
            return res;
        end
        full_base = (64'(req.counter) % longint'(dpsa_pkg::FRAMES_IN_FLIGHT))
                    * longint'(dpsa_pkg::PALETTE_SLOTS) * longint'(dpsa_pkg::BONES_PER_POSE)
                    + longint'(slot_fill) * longint'(dpsa_pkg::BONES_PER_POSE);
        res.base_valid          = 1'b1;
        res.newly               = 1'b1;
        res.base                = dpsa_pkg::BASE_W'(full_base);
        stored_keys[slot_fill]  = key;
        stored_bases[slot_fill] = res.base;
        slot_fill++;
        return res;
    endfunction

    // Builds a request; the key goes to the field that pose_present selects
    function automatic t_palette_req make_request(input bit skin, input bit ready,
                                                  input bit pose_present,
                                                  input bit [dpsa_pkg::KEY_W-1:0] key,
                                                  input bit [dpsa_pkg::SERIAL_W-1:0] serial,
                                                  input bit [dpsa_pkg::COUNTER_W-1:0] counter);
        t_palette_req req;
        req.skin         = skin;
        req.ready        = ready;
        req.pose_present = pose_present;
        req.pose_id      = pose_present ? key : {$urandom, $urandom};
        req.req_id       = pose_present ? {$urandom, $urandom} : key;
        req.serial       = serial;
        req.counter      = counter;
        return req;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("MISMATCH result %0d %s: expected %0h, got %0h at %0t",
                 results_checked, field, want, got, $time);
        mismatch_count++;
    endtask

    // Sends one request; called and returns at a falling edge, tvalid left high
    task automatic send_request(input t_palette_req req);
        if (!calm_stretch && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid                    = 1'b1;
        s_axis_tdata                     = {req.counter, req.serial, req.req_id, req.pose_id};
        s_axis_tuser[dpsa_pkg::IU_SKIN]  = req.skin;
        s_axis_tuser[dpsa_pkg::IU_READY] = req.ready;
        s_axis_tuser[dpsa_pkg::IU_POSE]  = req.pose_present;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_bases.push_back(allocate_palette_base(req));
        @(negedge i_clk);
    endtask

    // Receiver back-pressure: short stalls, now and then a long one
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_stretch) begin
                m_axis_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < 13) begin
                m_axis_tready = 1'b0;
                stall_left    = ($urandom_range(0, 99) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(0, 2);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Result checker: each transfer against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_palette_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bases.size() == 0) begin
                report_mismatch("unexpected result", '0, 64'({m_axis_tuser, m_axis_tdata}));
            end else begin
                want = expected_bases.pop_front();
                if (m_axis_tuser[dpsa_pkg::OU_VALID] !== want.base_valid)
                    report_mismatch("base_valid", 64'(want.base_valid),
                                    64'(m_axis_tuser[dpsa_pkg::OU_VALID]));
                if (m_axis_tdata !== dpsa_pkg::OUT_DATA_W'(want.base))
                    report_mismatch("palette_base", 64'(want.base), 64'(m_axis_tdata));
                if (m_axis_tuser[dpsa_pkg::OU_NEW] !== want.newly)
                    report_mismatch("newly_allocated", 64'(want.newly),
                                    64'(m_axis_tuser[dpsa_pkg::OU_NEW]));
                if (m_axis_tuser[dpsa_pkg::OU_OVF] !== want.overflow)
                    report_mismatch("overflow_report", 64'(want.overflow),
                                    64'(m_axis_tuser[dpsa_pkg::OU_OVF]));
            end
            results_checked++;
        end
    end

    // Not skinned or not ready: always invalid, serial ignored
    task automatic test_refused_requests();
        send_request(make_request(1'b0, 1'b1, 1'b0, '0, '1, '0));
        send_request(make_request(1'b1, 1'b0, 1'b1, '1, '1, '0));
        send_request(make_request(1'b0, 1'b0, 1'b0, 64'd42, 64'd0, 32'd7));
    endtask

    // Pose and requester ids share one key space; refusals leave the table
    task automatic test_key_sharing();
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, '1, '0));
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, '1, '0));
        send_request(make_request(1'b1, 1'b1, 1'b1, '0, '1, '0));
        send_request(make_request(1'b1, 1'b1, 1'b1, '1, '1, '0));
        send_request(make_request(1'b1, 1'b1, 1'b0, '1, '1, '0));
        send_request(make_request(1'b0, 1'b1, 1'b1, '1, 64'd0, '0));
        send_request(make_request(1'b1, 1'b1, 1'b1, 64'h5555_5555_5555_5555, '1, '0));
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, '1, '0));
    endtask

    // Serial change empties the table; counter residue picks the frame region
    task automatic test_frame_restart();
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, 64'd0, 32'd1));
        send_request(make_request(1'b1, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 32'd2));
        send_request(make_request(1'b1, 1'b1, 1'b0, 64'h1234, 64'd0, '1));
        send_request(make_request(1'b1, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 32'd0));
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, 64'h8000_0000_0000_0000,
                                  32'hFFFF_FFFE));
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, 64'h8000_0000_0000_0000, 32'd1));
        send_request(make_request(1'b1, 1'b1, 1'b0, '0, '1, '0));
    endtask

    // Fills every slot in one frame, then drives the table past full
    task automatic test_table_full(input int residue);
        t_palette_req                 req;
        bit [dpsa_pkg::KEY_W-1:0]     keys[$];
        bit [dpsa_pkg::KEY_W-1:0]     key;
        bit [dpsa_pkg::SERIAL_W-1:0]  serial;
        bit [dpsa_pkg::COUNTER_W-1:0] counter;
        serial  = {$urandom, $urandom};
        counter = $urandom_range(0, 1431655000) * 3 + residue;
        do begin
            if (keys.size() > 0 && $urandom_range(0, 7) == 0) begin
                key = keys[$urandom_range(0, keys.size() - 1)];
            end else begin
                key = {$urandom, $urandom};
                keys.push_back(key);
            end
            req = make_request(1'b1, 1'b1, $urandom_range(0, 1), key, serial, counter);
            if ($urandom_range(0, 15) == 0)
                {req.skin, req.ready} = 2'($urandom_range(0, 2));
            send_request(req);
        end while (!(last_serial == serial && slot_fill == dpsa_pkg::PALETTE_SLOTS));
        // past full: report once, then silent; known keys still hit
        send_request(make_request(1'b1, 1'b1, 1'b0, {$urandom, $urandom}, serial, counter));
        send_request(make_request(1'b1, 1'b1, 1'b1, {$urandom, $urandom}, serial, counter));
        send_request(make_request(1'b1, 1'b1, $urandom_range(0, 1),
                                  keys[$urandom_range(0, keys.size() - 1)], serial, counter));
        send_request(make_request(1'b0, 1'b1, 1'b0, {$urandom, $urandom}, serial, counter));
        send_request(make_request(1'b1, 1'b1, 1'b1, keys[keys.size() - 1], serial, counter));
        send_request(make_request(1'b1, 1'b1, 1'b0, {$urandom, $urandom}, serial, $urandom));
    endtask

    // Random frames drawing keys from a small pool, with some noise
    task automatic test_random_traffic(input int n_items);
        t_palette_req                 req;
        bit [dpsa_pkg::KEY_W-1:0]     pool[$];
        bit [dpsa_pkg::KEY_W-1:0]     key;
        bit [dpsa_pkg::SERIAL_W-1:0]  serial;
        bit [dpsa_pkg::COUNTER_W-1:0] counter;
        int                           sent;
        int                           frame_len;
        int                           k;
        int                           pick;
        sent   = 0;
        serial = {$urandom, $urandom};
        while (sent < n_items) begin
            case ($urandom_range(0, 7))
                0:       serial = '1;
                1:       serial = '0;
                2, 3:    serial = {$urandom, $urandom};
                default: serial = serial + 1;
            endcase
            if ($urandom_range(0, 3) == 0)
                counter = $urandom_range(0, 1) ? '1 : '0;
            else
                counter = $urandom;
            pool.delete();
            repeat ($urandom_range(1, 24)) pool.push_back({$urandom, $urandom});
            frame_len = $urandom_range(1, 40);
            for (k = 0; k < frame_len && sent < n_items; k++) begin
                calm_stretch = (sent >= n_items / 4) && (sent < n_items / 2);
                key = pool[$urandom_range(0, pool.size() - 1)];
                if ($urandom_range(0, 15) == 0)
                    key = {$urandom, $urandom};
                req = make_request(1'b1, 1'b1, $urandom_range(0, 1), key, serial, counter);
                // unused id field sometimes holds a live key to catch a wrong select
                if ($urandom_range(0, 3) == 0) begin
                    if (req.pose_present)
                        req.req_id = pool[$urandom_range(0, pool.size() - 1)];
                    else
                        req.pose_id = pool[$urandom_range(0, pool.size() - 1)];
                end
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    {req.skin, req.ready} = 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 1))
                        req.serial = {$urandom, $urandom};
                end else if (pick < 13) begin
                    req.serial = {$urandom, $urandom};
                end
                if ($urandom_range(0, 7) == 0)
                    counter = $urandom;
                send_request(req);
                sent++;
            end
        end
        calm_stretch = 1'b0;
    endtask

    // Test sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_refused_requests();
        test_key_sharing();
        test_frame_restart();
        test_table_full(2);
        test_random_traffic(300);

        s_axis_tvalid = 1'b0;
        while (expected_bases.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

endmodule
